### design/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### design/mfpc_pkg.sv
// Types, constants and the CRC byte update shared by the frame checker modules.
package mfpc_pkg;

    localparam int MAX_FRAME_BYTES = 128;
    localparam int POS_W           = 8;
    localparam int NUM_LANES       = 8;
    localparam int LANE_W          = 3;
    localparam int CFG_IDX_W       = 4;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = 2;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  TYPE_OK  = 8'h2A;
    localparam logic [7:0]  SUB_A    = 8'h55;
    localparam logic [7:0]  SUB_B    = 8'hD2;
    localparam logic [7:0]  SUB_C    = 8'hD5;
    localparam logic [15:0] LONG_LEN = 16'h0047;

    localparam int DEST_LO   = 7;
    localparam int DEST_HI   = 12;
    localparam int SRC_LO    = 26;
    localparam int SRC_HI    = 29;
    localparam int WAN_A_LO  = 13;
    localparam int WAN_A_HI  = 18;
    localparam int UPT_A_LO  = 20;
    localparam int UPT_A_HI  = 23;
    localparam int WAN_C_LO  = 32;
    localparam int WAN_C_HI  = 37;
    localparam int UPT_C_LO  = 24;
    localparam int UPT_C_HI  = 27;
    localparam int CLK_C_LO  = 16;
    localparam int CLK_C_HI  = 19;

    typedef logic [15:0] t_crc_array [NUM_LANES];

    localparam t_crc_array CRC_INIT_RESET = '{
        16'hE623, 16'h5FD6, 16'hD553, 16'h45F8,
        16'h62C1, 16'h23D1, 16'h2C22, 16'h142A
    };

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDER     = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_BAD_SUB   = 3'd3,
        ST_TOO_SHORT = 3'd4,
        ST_CRC_FAIL  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic [7:0]  subtype;
        logic [15:0] frame_length;
        logic [2:0]  crc_init_index;
        logic [31:0] source_id;
        logic [47:0] dest_address;
        logic [47:0] source_wan;
        logic [31:0] uptime_seconds;
        logic [31:0] clock_seconds;
        logic        has_time_fields;
        logic        has_clock;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] r;
        r = c ^ {v, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### design/meter_frame_parse_crc_check_core.sv
// Top level of the meter frame parser and CRC checker.
// One byte per cycle while the input is not stalled: all eight CRC lanes update together in the frame engine.
// A result is registered after its last byte is accepted: the byte is first written into the
// queue, and the frame engine then pops it and loads the output register; a
// last byte waits in the queue while the output register holds a result not yet taken.
// Synchronous active-low reset empties queue and output, clears frame state, restores inits.
module meter_frame_parse_crc_check_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mfpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_in_data_byte,
    input  logic                           i_in_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_out_status,
    output logic [7:0]                     o_out_subtype,
    output logic [15:0]                    o_out_frame_length,
    output logic [2:0]                     o_out_crc_init_index,
    output logic [31:0]                    o_out_source_id,
    output logic [47:0]                    o_out_dest_address,
    output logic [47:0]                    o_out_source_wan,
    output logic [31:0]                    o_out_uptime_seconds,
    output logic [31:0]                    o_out_clock_seconds,
    output logic                           o_out_has_time_fields,
    output logic                           o_out_has_clock
);
    import mfpc_pkg::*;

    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;
    t_entry  push_entry;
    t_entry  q_entry;
    t_result result;

    mfpc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_data_byte (i_in_data_byte),
        .i_in_last_byte (i_in_last_byte),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    mfpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    mfpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_out_status          = result.status;
    assign o_out_subtype         = result.subtype;
    assign o_out_frame_length    = result.frame_length;
    assign o_out_crc_init_index  = result.crc_init_index;
    assign o_out_source_id       = result.source_id;
    assign o_out_dest_address    = result.dest_address;
    assign o_out_source_wan      = result.source_wan;
    assign o_out_uptime_seconds  = result.uptime_seconds;
    assign o_out_clock_seconds   = result.clock_seconds;
    assign o_out_has_time_fields = result.has_time_fields;
    assign o_out_has_clock       = result.has_clock;

endmodule

### design/mfpc_front.sv
// Input side: accepts frame bytes and tags each with its position in the frame.
module mfpc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_in_data_byte,
    input  logic            i_in_last_byte,
    input  logic            i_q_full,
    output logic            o_push,
    output mfpc_pkg::t_entry o_entry
);
    import mfpc_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    assign o_in_stall    = i_q_full;
    assign o_push        = i_in_valid && !i_q_full;
    assign o_entry.data  = i_in_data_byte;
    assign o_entry.pos   = r_pos;
    assign o_entry.last  = i_in_last_byte;

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_in_last_byte) begin
                n_pos = '0;
            end else if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

### design/mfpc_queue.sv
// Short queue of tagged bytes between the input side and the frame engine.
module mfpc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mfpc_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output mfpc_pkg::t_entry o_entry
);
    import mfpc_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/mfpc_back.sv
// Frame engine: CRC lanes, field capture, status decision and the result register.
module mfpc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mfpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_q_valid,
    input  mfpc_pkg::t_entry               i_q_entry,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mfpc_pkg::t_result              o_result
);
    import mfpc_pkg::*;

    logic [15:0] r_init  [NUM_LANES];
    logic [15:0] r_lanes [NUM_LANES];
    logic [15:0] n_lanes [NUM_LANES];
    logic [15:0] s_lanes [NUM_LANES];
    logic [7:0]  r_type, n_type, s_type;
    logic [7:0]  r_sub, n_sub, s_sub;
    logic [15:0] r_len, n_len, s_len;
    logic [15:0] r_rxcrc, n_rxcrc, s_rxcrc;
    logic [47:0] r_dest, n_dest, s_dest;
    logic [47:0] r_wan, n_wan, s_wan;
    logic [31:0] r_src, n_src, s_src;
    logic [31:0] r_upt, n_upt, s_upt;
    logic [31:0] r_clk, n_clk, s_clk;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic [7:0]       v;
    logic [POS_W-1:0] p;
    logic [16:0]      p17;
    logic [16:0]      len17;
    logic [POS_W-1:0] count;
    logic             drop;
    logic             wide_r, narrow_r;
    logic             wide_s, narrow_s;
    logic             found;
    logic [LANE_W-1:0] hit;

    assign o_pop       = i_q_valid && (!i_q_entry.last || !r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign v     = i_q_entry.data;
    assign p     = i_q_entry.pos;
    assign p17   = 17'(p);
    assign drop  = (p >= POS_W'(MAX_FRAME_BYTES));
    assign count = drop ? p : p + POS_W'(1);

    assign wide_r   = (r_sub == SUB_A) || (r_sub == SUB_C);
    assign narrow_r = (r_sub == SUB_B);

    always_comb begin
        s_lanes = r_lanes;
        s_type  = r_type;
        s_sub   = r_sub;
        s_len   = r_len;
        s_rxcrc = r_rxcrc;
        s_dest  = r_dest;
        s_wan   = r_wan;
        s_src   = r_src;
        s_upt   = r_upt;
        s_clk   = r_clk;
        len17   = 17'(r_len);
        if (o_pop && !drop) begin
            if (p == '0) begin
                s_lanes = r_init;
            end
            if (p == POS_W'(2)) begin
                s_type = v;
            end
            if (p == POS_W'(3)) begin
                s_sub = v;
            end
            if (p >= POS_W'(4) && r_type == TYPE_OK) begin
                if (wide_r) begin
                    if (p == POS_W'(4)) begin
                        s_len = {v, 8'h00};
                    end
                    if (p == POS_W'(5)) begin
                        s_len = {r_len[15:8], v};
                    end
                    len17 = 17'(s_len);
                    if (p >= POS_W'(5)) begin
                        if (p17 == len17 + 17'd4) begin
                            s_rxcrc[15:8] = v;
                        end
                        if (p17 == len17 + 17'd5) begin
                            s_rxcrc[7:0] = v;
                        end
                    end
                    if (p >= POS_W'(6) && p17 <= len17 + 17'd3) begin
                        for (int i = 0; i < NUM_LANES; i++) begin
                            s_lanes[i] = crc_byte(r_lanes[i], v);
                        end
                    end
                    for (int k = 0; k <= DEST_HI - DEST_LO; k++) begin
                        if (p == POS_W'(DEST_HI - k)) s_dest[8*k +: 8] = v;
                    end
                    for (int k = 0; k <= SRC_HI - SRC_LO; k++) begin
                        if (p == POS_W'(SRC_HI - k)) s_src[8*k +: 8] = v;
                    end
                    if (r_sub == SUB_A) begin
                        for (int k = 0; k <= WAN_A_HI - WAN_A_LO; k++) begin
                            if (p == POS_W'(WAN_A_HI - k)) s_wan[8*k +: 8] = v;
                        end
                        for (int k = 0; k <= UPT_A_HI - UPT_A_LO; k++) begin
                            if (p == POS_W'(UPT_A_HI - k)) s_upt[8*k +: 8] = v;
                        end
                    end else begin
                        for (int k = 0; k <= WAN_C_HI - WAN_C_LO; k++) begin
                            if (p == POS_W'(WAN_C_HI - k)) s_wan[8*k +: 8] = v;
                        end
                        for (int k = 0; k <= UPT_C_HI - UPT_C_LO; k++) begin
                            if (p == POS_W'(UPT_C_HI - k)) s_upt[8*k +: 8] = v;
                        end
                        for (int k = 0; k <= CLK_C_HI - CLK_C_LO; k++) begin
                            if (p == POS_W'(CLK_C_HI - k)) s_clk[8*k +: 8] = v;
                        end
                    end
                end else if (narrow_r) begin
                    if (p == POS_W'(4)) begin
                        s_len = {8'h00, v};
                        if (v == 8'h00) begin
                            s_rxcrc = {r_sub, 8'h00};
                        end
                    end
                    len17 = 17'(s_len);
                    if (p17 == len17 + 17'd3) begin
                        s_rxcrc[15:8] = v;
                    end
                    if (p17 == len17 + 17'd4) begin
                        s_rxcrc[7:0] = v;
                    end
                    if (p >= POS_W'(5) && p17 <= len17 + 17'd2) begin
                        for (int i = 0; i < NUM_LANES; i++) begin
                            s_lanes[i] = crc_byte(r_lanes[i], v);
                        end
                    end
                end
            end
        end
    end

    assign wide_s   = (s_sub == SUB_A) || (s_sub == SUB_C);
    assign narrow_s = (s_sub == SUB_B);

    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int i = NUM_LANES - 1; i >= 0; i--) begin
            if (s_lanes[i] == s_rxcrc) begin
                found = 1'b1;
                hit   = LANE_W'(i);
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (count < POS_W'(5)) begin
            n_out.status = ST_UNDER;
        end else if (s_type != TYPE_OK) begin
            n_out.status = ST_BAD_TYPE;
        end else if (!wide_s && !narrow_s) begin
            n_out.status = ST_BAD_SUB;
        end else if (17'(count) < 17'(s_len) + (wide_s ? 17'd6 : 17'd5)) begin
            n_out.status = ST_TOO_SHORT;
        end else if (!found) begin
            n_out.status = ST_CRC_FAIL;
        end else begin
            n_out.status = ST_OK;
        end
        n_out.subtype      = s_sub;
        n_out.frame_length = (wide_s || narrow_s) ? s_len : 16'h0000;
        if (n_out.status == ST_OK) begin
            n_out.crc_init_index = hit;
            if (s_sub == SUB_A) begin
                n_out.source_id       = s_src;
                n_out.dest_address    = s_dest;
                n_out.source_wan      = s_wan;
                n_out.uptime_seconds  = s_upt;
                n_out.has_time_fields = 1'b1;
            end else if (s_sub == SUB_C) begin
                n_out.source_id    = s_src;
                n_out.dest_address = {16'h0000, s_dest[47:16]};
                if (s_len == LONG_LEN) begin
                    n_out.source_wan      = s_wan;
                    n_out.uptime_seconds  = s_upt;
                    n_out.clock_seconds   = s_clk;
                    n_out.has_time_fields = 1'b1;
                    n_out.has_clock       = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_lanes = s_lanes;
        n_type  = s_type;
        n_sub   = s_sub;
        n_len   = s_len;
        n_rxcrc = s_rxcrc;
        n_dest  = s_dest;
        n_wan   = s_wan;
        n_src   = s_src;
        n_upt   = s_upt;
        n_clk   = s_clk;
        if (o_pop && i_q_entry.last) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                n_lanes[i] = '0;
            end
            n_type  = '0;
            n_sub   = '0;
            n_len   = '0;
            n_rxcrc = '0;
            n_dest  = '0;
            n_wan   = '0;
            n_src   = '0;
            n_upt   = '0;
            n_clk   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= CRC_INIT_RESET;
        end else if (i_cfg_we && i_cfg_index < CFG_IDX_W'(NUM_LANES)) begin
            r_init[i_cfg_index[LANE_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_lanes[i] <= '0;
            end
            r_type      <= '0;
            r_sub       <= '0;
            r_len       <= '0;
            r_rxcrc     <= '0;
            r_dest      <= '0;
            r_wan       <= '0;
            r_src       <= '0;
            r_upt       <= '0;
            r_clk       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lanes <= n_lanes;
            r_type  <= n_type;
            r_sub   <= n_sub;
            r_len   <= n_len;
            r_rxcrc <= n_rxcrc;
            r_dest  <= n_dest;
            r_wan   <= n_wan;
            r_src   <= n_src;
            r_upt   <= n_upt;
            r_clk   <= n_clk;
            if (o_pop && i_q_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_entry.last) begin
            r_out <= n_out;
        end
    end

endmodule

### design/mfpc_checker.sv
// Port-level checker for the frame checker core, bound to the top level.
`include "assert_macros.svh"

module mfpc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [mfpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [15:0]                    i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic [7:0]                     i_in_data_byte,
    input logic                           i_in_last_byte,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [2:0]                     o_out_status,
    input logic [7:0]                     o_out_subtype,
    input logic [15:0]                    o_out_frame_length,
    input logic [2:0]                     o_out_crc_init_index,
    input logic [31:0]                    o_out_source_id,
    input logic [47:0]                    o_out_dest_address,
    input logic [47:0]                    o_out_source_wan,
    input logic [31:0]                    o_out_uptime_seconds,
    input logic [31:0]                    o_out_clock_seconds,
    input logic                           o_out_has_time_fields,
    input logic                           o_out_has_clock
);
    import mfpc_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_status) && $stable(o_out_source_id) && $stable(o_out_dest_address))

    `ASSERT_IMPL(a_err_clears, i_clk, i_rst_n, o_out_valid && o_out_status != ST_OK, o_out_crc_init_index == 3'd0 && !o_out_has_time_fields && !o_out_has_clock && o_out_source_id == 32'd0)

    `ASSERT_IMPL(a_ok_subtype, i_clk, i_rst_n, o_out_valid && o_out_status == ST_OK, o_out_subtype == SUB_A || o_out_subtype == SUB_B || o_out_subtype == SUB_C)

    `ASSERT_IMPL(a_clock_long, i_clk, i_rst_n, o_out_valid && o_out_has_clock, o_out_has_time_fields && o_out_subtype == SUB_C && o_out_frame_length == LONG_LEN)

endmodule

bind meter_frame_parse_crc_check_core mfpc_checker u_mfpc_checker (.*);
